// ===== sv/spr_pkg.sv =====
// Shared types, constants and arctangent table function of the spherical point rotation.
`default_nettype none
package spr_pkg;

	localparam int VEC_FRAC = 30;
	localparam int VW = 34;
	localparam int PW = 2 * VW;
	localparam logic signed [VW-1:0] CORDIC_K = 34'sd652032874;
	localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

	typedef enum logic {
		CM_ROTATE,
		CM_VECTOR
	} spr_mode_t;

	typedef struct packed {
		logic signed [31:0] point_lat;
		logic signed [31:0] point_lon;
		logic signed [31:0] turn_lat;
		logic signed [31:0] turn_lon;
	} spr_in_t;

	typedef struct packed {
		logic signed [31:0] new_lat;
		logic signed [31:0] new_lon;
	} spr_out_t;

	// Restoring division, used only to build constants at elaboration.
	function automatic logic [63:0] spr_udiv(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Arctangent of 2^-idx as a binary angle of abits bits.
	function automatic logic [63:0] spr_atan(input int abits, input int idx);
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] hi;
		logic [127:0] prod;
		int e;
		sum = '0;
		if (idx == 0) begin
			return 64'd1 << (abits - 3);
		end
		for (int k = 0; k < 32; k++) begin
			e = idx * (2 * k + 1);
			if (e <= 62) begin
				term = spr_udiv(64'd1 << (62 - e), 64'(2 * k + 1));
				if ((k & 1) != 0) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		prod = {64'd0, sum} * {64'd0, INV_PI_Q64};
		hi = prod[127:64];
		return (hi + (64'd1 << (62 - abits))) >> (63 - abits);
	endfunction

endpackage
`default_nettype wire

// ===== sv/spr_cordic_cell.sv =====
// One CORDIC micro-rotation cell: a fixed shift and arctangent constant, registered outputs.
`default_nettype none
module spr_cordic_cell
	import spr_pkg::*;
#(
	parameter spr_mode_t MODE = CM_ROTATE,
	parameter int SHIFT = 0,
	parameter int ZW = 34,
	parameter int TW = 1,
	parameter logic [ZW-1:0] ATAN = '0
) (
	input  wire logic                 clk,
	input  wire logic signed [VW-1:0] x,
	input  wire logic signed [VW-1:0] y,
	input  wire logic signed [ZW-1:0] z,
	input  wire logic [TW-1:0]        tag,
	output logic signed [VW-1:0]      x_q,
	output logic signed [VW-1:0]      y_q,
	output logic signed [ZW-1:0]      z_q,
	output logic [TW-1:0]             tag_q
);

	logic signed [VW-1:0] xs;
	logic signed [VW-1:0] ys;
	logic sigma;

	assign xs = x >>> SHIFT;
	assign ys = y >>> SHIFT;
	// Rotation steers by the residual angle, vectoring by the sign of y.
	assign sigma = (MODE == CM_ROTATE) ? !z[ZW-1] : y[VW-1];

	always_ff @(posedge clk) begin
		if (sigma) begin
			x_q <= x - ys;
			y_q <= y + xs;
			z_q <= z - $signed(ATAN);
		end else begin
			x_q <= x + ys;
			y_q <= y - xs;
			z_q <= z + $signed(ATAN);
		end
		tag_q <= tag;
	end

endmodule
`default_nettype wire

// ===== sv/spherical_point_rotation_unit.sv =====
// Top level: sine/cosine cell rows, rotation matrix product, two atan2 cell rows.
// One transaction is accepted every cycle; busy stays low, as every stage is a register
// and the CORDIC rows advance one cell per cycle.
// Results cannot be stalled: done pulses for one cycle with the result.
// arst_n clears only the valid line; data registers are not reset.
`default_nettype none
module spherical_point_rotation_unit
	import spr_pkg::*;
#(
	parameter int ANGLE_BITS = 32,
	parameter int CORDIC_STEPS = 28
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire spr_in_t point,
	output logic      done,
	output spr_out_t  result
);

	localparam int A = ANGLE_BITS;
	localparam int N = CORDIC_STEPS;
	localparam int ZW = A + 2;
	localparam int LAT = 3 * N + 6;

	logic acc;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;
	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end
	assign done = vld_q[LAT-1];

	// Sine and cosine rows: 0 point_lat, 1 point_lon, 2 -turn_lat, 3 turn_lon.
	logic [31:0] ain [4];
	logic [A-1:0] ang [4];
	logic signed [VW-1:0] rx [4][N+1];
	logic signed [VW-1:0] ry [4][N+1];
	logic signed [ZW-1:0] rz [4][N+1];
	logic [0:0] rt [4][N+1];

	assign ain[0] = point.point_lat;
	assign ain[1] = point.point_lon;
	assign ain[2] = point.turn_lat;
	assign ain[3] = point.turn_lon;

	genvar c, i;
	generate
		for (c = 0; c < 4; c++) begin : g_trig
			logic [A-1:0] a0;
			logic [A-1:0] a2;
			logic flip;
			if (A >= 32) begin : g_up
				assign a0 = A'($unsigned(ain[c])) << (A - 32);
			end else begin : g_dn
				assign a0 = ain[c][31 -: A];
			end
			if (c == 2) begin : g_neg
				assign ang[c] = A'(0) - a0;
			end else begin : g_pos
				assign ang[c] = a0;
			end
			// Fold into the right half plane; the results are negated at the end.
			assign flip = ang[c][A-1] ^ ang[c][A-2];
			assign a2 = {ang[c][A-1] ^ flip, ang[c][A-2:0]};
			assign rx[c][0] = CORDIC_K;
			assign ry[c][0] = '0;
			assign rz[c][0] = {{2{a2[A-1]}}, a2};
			assign rt[c][0] = flip;
			for (i = 0; i < N; i++) begin : g_cell
				localparam logic [63:0] TF = spr_atan(A, i);
				spr_cordic_cell #(
					.MODE(CM_ROTATE), .SHIFT(i), .ZW(ZW), .TW(1), .ATAN(TF[ZW-1:0])
				) u_cell (
					.clk(clk), .x(rx[c][i]), .y(ry[c][i]), .z(rz[c][i]), .tag(rt[c][i]),
					.x_q(rx[c][i+1]), .y_q(ry[c][i+1]), .z_q(rz[c][i+1]),
					.tag_q(rt[c][i+1])
				);
			end
		end
	endgenerate

	logic signed [VW-1:0] cos_s1 [4];
	logic signed [VW-1:0] sin_s1 [4];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			cos_s1[k] <= rt[k][N][0] ? -rx[k][N] : rx[k][N];
			sin_s1[k] <= rt[k][N][0] ? -ry[k][N] : ry[k][N];
		end
	end

	function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b);
		return VW'(p >>> VEC_FRAC);
	endfunction

	logic signed [VW-1:0] vx_s2, vy_s2, vz_s2;
	logic signed [VW-1:0] r11_s2, r12_s2, r13_s2, r21_s2, r22_s2, r31_s2, r32_s2, r33_s2;

	always_ff @(posedge clk) begin
		vx_s2  <= -fmul(cos_s1[0], cos_s1[1]);
		vy_s2  <= fmul(cos_s1[0], sin_s1[1]);
		vz_s2  <= sin_s1[0];
		r11_s2 <= fmul(cos_s1[2], cos_s1[3]);
		r12_s2 <= -fmul(cos_s1[2], sin_s1[3]);
		r13_s2 <= sin_s1[2];
		r21_s2 <= sin_s1[3];
		r22_s2 <= cos_s1[3];
		r31_s2 <= -fmul(sin_s1[2], cos_s1[3]);
		r32_s2 <= fmul(sin_s1[2], sin_s1[3]);
		r33_s2 <= cos_s1[2];
	end

	logic signed [PW-1:0] p_s3 [8];

	always_ff @(posedge clk) begin
		p_s3[0] <= PW'(vx_s2) * PW'(r11_s2);
		p_s3[1] <= PW'(vy_s2) * PW'(r12_s2);
		p_s3[2] <= PW'(vz_s2) * PW'(r13_s2);
		p_s3[3] <= PW'(vx_s2) * PW'(r21_s2);
		p_s3[4] <= PW'(vy_s2) * PW'(r22_s2);
		p_s3[5] <= PW'(vx_s2) * PW'(r31_s2);
		p_s3[6] <= PW'(vy_s2) * PW'(r32_s2);
		p_s3[7] <= PW'(vz_s2) * PW'(r33_s2);
	end

	logic signed [PW+1:0] sx, sy, sz;
	logic signed [VW-1:0] nx_s4, ny_s4, nz_s4;

	assign sx = (PW+2)'(p_s3[0]) + (PW+2)'(p_s3[1]) + (PW+2)'(p_s3[2]);
	assign sy = (PW+2)'(p_s3[3]) + (PW+2)'(p_s3[4]);
	assign sz = (PW+2)'(p_s3[5]) + (PW+2)'(p_s3[6]) + (PW+2)'(p_s3[7]);

	always_ff @(posedge clk) begin
		nx_s4 <= VW'(sx >>> VEC_FRAC);
		ny_s4 <= VW'(sy >>> VEC_FRAC);
		nz_s4 <= VW'(sz >>> VEC_FRAC);
	end

	// Longitude row: atan2(ny, nx) and magnitude; nz rides along in the tag.
	localparam int LTW = VW + 2;
	logic signed [VW-1:0] lx [N+1];
	logic signed [VW-1:0] ly [N+1];
	logic signed [ZW-1:0] lz [N+1];
	logic [LTW-1:0] lt [N+1];
	logic lneg, lzero;

	assign lzero = (nx_s4 == '0) && (ny_s4 == '0);
	assign lneg = nx_s4[VW-1];
	assign lx[0] = lneg ? -nx_s4 : nx_s4;
	assign ly[0] = lneg ? -ny_s4 : ny_s4;
	assign lz[0] = '0;
	assign lt[0] = {nz_s4, lneg, lzero};

	generate
		for (i = 0; i < N; i++) begin : g_lon
			localparam logic [63:0] TF = spr_atan(A, i);
			spr_cordic_cell #(
				.MODE(CM_VECTOR), .SHIFT(i), .ZW(ZW), .TW(LTW), .ATAN(TF[ZW-1:0])
			) u_cell (
				.clk(clk), .x(lx[i]), .y(ly[i]), .z(lz[i]), .tag(lt[i]),
				.x_q(lx[i+1]), .y_q(ly[i+1]), .z_q(lz[i+1]), .tag_q(lt[i+1])
			);
		end
	endgenerate

	logic [A-1:0] lon_s5;
	logic signed [VW-1:0] mag_s5, nz_s5;
	logic signed [PW-1:0] mprod;

	assign mprod = PW'(lx[N]) * PW'(CORDIC_K);

	always_ff @(posedge clk) begin
		if (lt[N][0]) begin
			lon_s5 <= '0;
			mag_s5 <= '0;
		end else begin
			lon_s5 <= lz[N][A-1:0] + {lt[N][1], {(A-1){1'b0}}};
			mag_s5 <= VW'(mprod >>> VEC_FRAC);
		end
		nz_s5 <= lt[N][LTW-1:2];
	end

	// Latitude row: atan2(nz, magnitude); the longitude rides along in the tag.
	localparam int ATW = A + 2;
	logic signed [VW-1:0] ax [N+1];
	logic signed [VW-1:0] ay [N+1];
	logic signed [ZW-1:0] az [N+1];
	logic [ATW-1:0] at [N+1];
	logic aneg, azero;

	assign azero = (mag_s5 == '0) && (nz_s5 == '0);
	assign aneg = mag_s5[VW-1];
	assign ax[0] = aneg ? -mag_s5 : mag_s5;
	assign ay[0] = aneg ? -nz_s5 : nz_s5;
	assign az[0] = '0;
	assign at[0] = {lon_s5, aneg, azero};

	generate
		for (i = 0; i < N; i++) begin : g_lat
			localparam logic [63:0] TF = spr_atan(A, i);
			spr_cordic_cell #(
				.MODE(CM_VECTOR), .SHIFT(i), .ZW(ZW), .TW(ATW), .ATAN(TF[ZW-1:0])
			) u_cell (
				.clk(clk), .x(ax[i]), .y(ay[i]), .z(az[i]), .tag(at[i]),
				.x_q(ax[i+1]), .y_q(ay[i+1]), .z_q(az[i+1]), .tag_q(at[i+1])
			);
		end
	endgenerate

	logic [A-1:0] lat_f, lon_f;
	logic [31:0] lat_o, lon_o;

	assign lat_f = at[N][0] ? '0 : (az[N][A-1:0] + {at[N][1], {(A-1){1'b0}}});
	assign lon_f = at[N][ATW-1:2];

	generate
		if (A >= 32) begin : g_out_dn
			assign lat_o = lat_f[A-1 -: 32];
			assign lon_o = lon_f[A-1 -: 32];
		end else begin : g_out_up
			assign lat_o = 32'(lat_f) << (32 - A);
			assign lon_o = 32'(lon_f) << (32 - A);
		end
	endgenerate

	always_ff @(posedge clk) begin
		result.new_lat <= lat_o;
		result.new_lon <= lon_o;
	end

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("done without a transaction accepted LAT cycles earlier");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised in a fully pipelined unit");

	a_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(acc ##1 acc) |-> ##(LAT-1) (done ##1 done))
		else $error("consecutive transactions did not complete on consecutive cycles");

endmodule
`default_nettype wire

// ===== sim/tb_spherical_point_rotation_unit.sv =====
// Self-checking testbench of the spherical point rotation unit: directed table, then random points.
`timescale 1ns / 1ps
module tb_spherical_point_rotation_unit;
	import spr_pkg::*;

	localparam int NSTEPS = 28;
	localparam int LATENCY = 3 * NSTEPS + 6;
	localparam int N_RANDOM = 1530;
	localparam int N_TABLE = 12;
	localparam longint PI_BA = 64'sd2147483648;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	spr_in_t point;
	logic done;
	spr_out_t result;

	spherical_point_rotation_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point(point), .done(done), .result(result)
	);

	longint atan_rom [NSTEPS];
	spr_out_t rotated_q [$];
	int mismatches;
	int checked;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Timeout after %0d results", checked);
		$display("Mismatches found");
		$finish;
	end

	function automatic longint sra(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint wrap_angle(longint a);
		return longint'(signed'(a[31:0]));
	endfunction

	// Rotation mode; angles outside [-pi/2, pi/2) are shifted by pi and the result negated.
	function automatic void sin_cos(input longint ang, output longint c, output longint s);
		longint x, y, z, nx;
		logic [31:0] a;
		logic flip;
		a = ang[31:0];
		flip = a[31] ^ a[30];
		if (flip) a[31] = ~a[31];
		z = longint'(signed'(a));
		x = CORDIC_K;
		y = 0;
		for (int i = 0; i < NSTEPS; i++) begin
			if (z >= 0) begin
				nx = x - sra(y, i); y = y + sra(x, i); z -= atan_rom[i];
			end else begin
				nx = x + sra(y, i); y = y - sra(x, i); z += atan_rom[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic void vector_angle(input longint yi, input longint xi,
			output longint ang, output longint mag);
		longint x, y, z, nx, off;
		x = xi; y = yi; z = 0; off = 0;
		if (x == 0 && y == 0) begin
			ang = 0; mag = 0;
			return;
		end
		if (x < 0) begin
			x = -x; y = -y; off = PI_BA;
		end
		for (int i = 0; i < NSTEPS; i++) begin
			if (y >= 0) begin
				nx = x + sra(y, i); y = y - sra(x, i); z += atan_rom[i];
			end else begin
				nx = x - sra(y, i); y = y + sra(x, i); z -= atan_rom[i];
			end
			x = nx;
		end
		mag = sra(x * longint'(CORDIC_K), VEC_FRAC);
		ang = wrap_angle(z + off);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return sra(a * b, VEC_FRAC);
	endfunction

	function automatic spr_out_t rotate_point(spr_in_t p);
		longint cl, sl, co, so, cy, sy, cz, sz, x, y, z;
		longint r11, r12, r13, r31, r32, r33, nx, ny, nz, mag, unused, la, lo;
		spr_out_t r;
		sin_cos(longint'(p.point_lat), cl, sl);
		sin_cos(longint'(p.point_lon), co, so);
		sin_cos(-longint'(p.turn_lat), cy, sy);
		sin_cos(longint'(p.turn_lon), cz, sz);
		x = -qmul(cl, co);
		y = qmul(cl, so);
		z = sl;
		r11 = qmul(cy, cz); r12 = -qmul(cy, sz); r13 = sy;
		r31 = -qmul(sy, cz); r32 = qmul(sy, sz); r33 = cy;
		nx = sra(x * r11 + y * r12 + z * r13, VEC_FRAC);
		ny = sra(x * sz + y * cz, VEC_FRAC);
		nz = sra(x * r31 + y * r32 + z * r33, VEC_FRAC);
		vector_angle(ny, nx, lo, mag);
		vector_angle(nz, mag, la, unused);
		r.new_lat = la[31:0];
		r.new_lon = lo[31:0];
		return r;
	endfunction

	function automatic logic [31:0] random_angle();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h4000_0000;
			3: return 32'hc000_0000;
			4: return 32'(signed'($urandom_range(0, 64)) - 32);
			default: return $urandom();
		endcase
	endfunction

	// Directed rows; the known field flags an expected value known by hand.
	typedef struct {
		spr_in_t p;
		bit known;
		spr_out_t want;
	} table_row_t;

	table_row_t tbl [N_TABLE];

	initial begin
		tbl[0] = '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0};
		tbl[1] = '{'{32'sh4000_0000, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0};
		tbl[2] = '{'{32'shc000_0000, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0};
		tbl[3] = '{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1'b0, '0};
		tbl[4] = '{'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1'b0, '0};
		tbl[5] = '{'{32'sd0, 32'sh8000_0000, 32'sd0, 32'sd0}, 1'b0, '0};
		tbl[6] = '{'{32'sd0, 32'sd0, 32'sh4000_0000, 32'sd0}, 1'b0, '0};
		tbl[7] = '{'{32'sd0, 32'sd0, 32'sd0, 32'sh4000_0000}, 1'b0, '0};
		tbl[8] = '{'{32'sd0, 32'sh4000_0000, 32'sd0, 32'shc000_0000}, 1'b0, '0};
		tbl[9] = '{'{32'sh2000_0000, 32'sh1234_5678, 32'she000_0000, 32'sh1234_5678}, 1'b0, '0};
		tbl[10] = '{'{32'sd1, 32'shffff_ffff, 32'shffff_ffff, 32'sd1}, 1'b0, '0};
		tbl[11] = '{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa}, 1'b0, '0};
	end

	// Sends one transaction, first idling at random (27 percent odds on each try) when allow_idle is set.
	task automatic send_point(input spr_in_t p, input bit known, input spr_out_t want,
			input bit allow_idle);
		while (allow_idle && $urandom_range(0, 99) < 27) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		rotated_q.push_back(known ? want : rotate_point(p));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (rotated_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %h", result);
			end else begin
				spr_out_t exp_r;
				exp_r = rotated_q.pop_front();
				checked++;
				if (result.new_lat !== exp_r.new_lat || result.new_lon !== exp_r.new_lon) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: lat exp %h got %h, lon exp %h got %h",
							exp_r.new_lat, result.new_lat, exp_r.new_lon, result.new_lon);
				end
			end
		end
	end

	initial begin
		spr_in_t p;
		int waited;
		mismatches = 0;
		checked = 0;
		for (int i = 0; i < NSTEPS; i++) atan_rom[i] = longint'(spr_atan(32, i));
		arst_n = 1'b0;
		start = 1'b0;
		point = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_TABLE; i++)
			send_point(tbl[i].p, tbl[i].known, tbl[i].want, 1'b1);
		for (int i = 0; i < N_RANDOM; i++) begin
			p.point_lat = random_angle();
			p.point_lon = random_angle();
			p.turn_lat = random_angle();
			p.turn_lon = random_angle();
			// A back-to-back stretch in the middle of the random part.
			send_point(p, 1'b0, '0, !(i >= 600 && i < 900));
		end
		start <= 1'b0;
		waited = 0;
		while (rotated_q.size() != 0 && waited < 4 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY) @(posedge clk);
		$display("Checked %0d rotated points: %0d directed rows and %0d random ones.",
			checked, N_TABLE, N_RANDOM);
		if (mismatches == 0 && rotated_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, rotated_q.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/spr_pkg.sv
sv/spr_cordic_cell.sv
sv/spherical_point_rotation_unit.sv
sim/tb_spherical_point_rotation_unit.sv
